@@ sv/stnvm_pkg.sv @@
package stnvm_pkg;

	// Input function codes.
	localparam logic [2:0] FUNC_TICK   = 3'd0;
	localparam logic [2:0] FUNC_PSTART = 3'd1;
	localparam logic [2:0] FUNC_PSTOP  = 3'd2;
	localparam logic [2:0] FUNC_TSTART = 3'd3;
	localparam logic [2:0] FUNC_TSTOP  = 3'd4;
	localparam logic [2:0] FUNC_DRUM   = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [1:0] REG_MASTER_VOL  = 2'd1;
	localparam logic [1:0] REG_MUSIC_EN    = 2'd2;

	// Shared arithmetic unit widths.
	localparam int OPW = 20;
	localparam int PRW = 40;

	localparam logic [16:0] LEVEL_FULL = 17'd65536;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EVENT,
		S_TGT,
		S_DRUM_MUL,
		S_DRUM_DIV1,
		S_DRUM_DIV2,
		S_P_CHK,
		S_P_GAIN,
		S_P_ENV,
		S_P_ENVMUL,
		S_P_ENVDIV,
		S_P_NEXT,
		S_TRI_CHK,
		S_TRI_MUL,
		S_TRI_DIV,
		S_NOISE_CHK,
		S_NOISE_MUL,
		S_VOL_CHK,
		S_VOL_MUL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic           start;
		logic [OPW-1:0] a;
		logic [OPW-1:0] b;
		logic [4:0]     nbits;
	} mul_req_t;

	typedef struct packed {
		logic           start;
		logic [PRW-1:0] dividend;
		logic [OPW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       tap_sel;
		logic [4:0] clk_div;
		logic [7:0] ms;
	} drum_t;

	// Drum presets: LFSR tap, clock divider and decay time in ms.
	function automatic drum_t drum_preset(input logic [1:0] kind);
		drum_t d;
		unique case (kind)
			2'd0: d = '{tap_sel: 1'b0, clk_div: 5'd16, ms: 8'd90};
			2'd1: d = '{tap_sel: 1'b0, clk_div: 5'd4,  ms: 8'd120};
			2'd2: d = '{tap_sel: 1'b1, clk_div: 5'd1,  ms: 8'd30};
			default: d = '{tap_sel: 1'b1, clk_div: 5'd1, ms: 8'd150};
		endcase
		return d;
	endfunction

	// Phase limit below which the pulse output is high.
	function automatic logic [16:0] duty_limit(input logic [1:0] code);
		logic [16:0] lim;
		unique case (code)
			2'd0: lim = 17'd8192;
			2'd1: lim = 17'd16384;
			default: lim = 17'd32768;
		endcase
		return lim;
	endfunction

endpackage

@@ sv/stnvm_mul.sv @@
module stnvm_mul
	import stnvm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  mul_req_t       req,
	output logic           done,
	output logic [PRW-1:0] prod
);

	logic           busy_q;
	logic           done_q;
	logic [4:0]     cnt_q;
	logic [PRW-1:0] acc_q;
	logic [PRW-1:0] a_q;
	logic [OPW-1:0] b_q;

	// Control: count multiplier bits, flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift-add datapath, one multiplier bit per cycle, LSB first.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= PRW'(req.a);
			b_q   <= req.b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[PRW-2:0], 1'b0};
			b_q <= {1'b0, b_q[OPW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ sv/stnvm_div.sv @@
module stnvm_div
	import stnvm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  div_req_t       req,
	output logic           done,
	output logic [PRW-1:0] quot
);

	logic           busy_q;
	logic           done_q;
	logic [5:0]     cnt_q;
	logic [OPW-1:0] rem_q;
	logic [OPW-1:0] d_q;
	logic [PRW-1:0] q_q;
	logic [OPW:0]   r2;
	logic           ge;

	// One restoring step: bring down the next dividend bit.
	assign r2 = {rem_q, q_q[PRW-1]};
	assign ge = (r2 >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(PRW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Quotient bits shift in where the dividend bits leave.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			d_q   <= req.divisor;
			q_q   <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? OPW'(r2 - {1'b0, d_q}) : r2[OPW-1:0];
			q_q   <= {q_q[PRW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

@@ sv/square_triangle_noise_voice_mixer.sv @@
// A note event is applied directly; a pulse start below full sustain runs one
// 40-step divide and a drum trigger one 8-step multiply and two 40-step divides.
// A tick runs a gain multiply per sounding pulse voice, plus an envelope multiply
// and divide per pulse voice in decay, a multiply and divide for the triangle and
// multiplies for the noise and the volume scaling. One transaction is worked on at
// a time, the next only once back in idle; a result may wait in the output register.
// Reset is asynchronous, active low, and restores all voice state and the configuration registers.
module square_triangle_noise_voice_mixer
	import stnvm_pkg::*;
#(
	parameter int NUM_PULSE = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic        voice,
	input  logic [15:0] phase_inc,
	input  logic [1:0]  duty_code,
	input  logic [7:0]  gain,
	input  logic [6:0]  sustain_pct,
	input  logic [19:0] decay_samples,
	input  logic [1:0]  drum_kind,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] sample,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [16:0] cfg_wdata
);

	localparam int PIW = (NUM_PULSE > 1) ? $clog2(NUM_PULSE) : 1;

	state_t state_q, state_d;

	// Configuration registers.
	logic [16:0] sample_rate_q;
	logic [3:0]  master_volume_q;
	logic        music_enable_q;

	// Latched transaction fields.
	logic [2:0]  func_q;
	logic        voice_q;
	logic [15:0] inc_q;
	logic [1:0]  duty_q;
	logic [7:0]  gain_q;
	logic [6:0]  sus_q;
	logic [19:0] dec_q;
	logic [1:0]  kind_q;

	// Pulse voices.
	logic [15:0] p_phase_q  [NUM_PULSE];
	logic [15:0] p_step_q   [NUM_PULSE];
	logic        p_active_q [NUM_PULSE];
	logic [1:0]  p_duty_q   [NUM_PULSE];
	logic [7:0]  p_gain_q   [NUM_PULSE];
	logic [16:0] p_level_q  [NUM_PULSE];
	logic [16:0] p_target_q [NUM_PULSE];
	logic [19:0] p_total_q  [NUM_PULSE];
	logic [19:0] p_left_q   [NUM_PULSE];

	// Triangle voice.
	logic [15:0] t_phase_q;
	logic [15:0] t_step_q;
	logic        t_active_q;
	logic [7:0]  t_gain_q;

	// Noise voice.
	logic [14:0] n_shift_q;
	logic        n_tap_q;
	logic [4:0]  n_div_q;
	logic [4:0]  n_cnt_q;
	logic [16:0] n_level_q;
	logic [16:0] n_fall_q;
	logic [7:0]  n_gain_q;

	// Tick working registers.
	logic [PIW-1:0]     idx_q;
	logic signed [11:0] mix_q;
	logic signed [15:0] res_q;
	logic               launched_q;
	logic               out_valid_q;
	logic signed [15:0] sample_q;

	// Shared units.
	mul_req_t       mul_req;
	div_req_t       div_req;
	logic           mul_done;
	logic           div_done;
	logic [PRW-1:0] mul_prod;
	logic [PRW-1:0] div_quot;

	stnvm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	stnvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Derived values for the addressed pulse voice and the other voices.
	logic        voice_ok;
	logic        accept;
	drum_t       drum;
	logic [3:0]  vol;
	logic [6:0]  vol_k;
	logic [10:0] mix_mag;
	logic        mix_neg;
	logic [3:0]  t_amp;
	logic [3:0]  t_mag;
	logic        t_neg;
	logic [19:0] p_gone;
	logic [16:0] p_drop;
	logic        p_pos;
	logic [19:0] drum_n;
	logic [16:0] n_fall_new;
	logic [4:0]  n_cnt_inc;
	logic        n_fb;
	logic [14:0] n_shift_new;
	logic [17:0] vol_prod;

	assign voice_ok   = (32'(voice_q) < NUM_PULSE);
	assign accept     = in_valid && in_ready;
	assign drum       = drum_preset(kind_q);
	assign vol        = (master_volume_q > 4'd10) ? 4'd10 : master_volume_q;
	assign vol_k      = 7'({vol, 3'b000}) + 7'({vol, 1'b0}) + 7'(vol);
	assign mix_neg    = mix_q[11];
	assign mix_mag    = mix_neg ? 11'(-mix_q) : mix_q[10:0];
	assign t_amp      = t_phase_q[15] ? t_phase_q[14:11] : 4'd15 - t_phase_q[14:11];
	assign t_neg      = !t_amp[3];
	assign t_mag      = t_amp[3] ? 4'({1'b0, t_amp, 1'b0} - 6'd15)
	                             : 4'(6'd15 - {1'b0, t_amp, 1'b0});
	assign p_gone     = p_total_q[idx_q] - p_left_q[idx_q];
	assign p_drop     = LEVEL_FULL - p_target_q[idx_q];
	assign p_pos      = ({1'b0, p_phase_q[idx_q]} < duty_limit(p_duty_q[idx_q]));
	assign drum_n     = (div_quot[19:0] == 20'd0) ? 20'd1 : div_quot[19:0];
	assign n_fall_new = (div_quot[16:0] == 17'd0) ? 17'd1 : div_quot[16:0];
	assign n_cnt_inc  = n_cnt_q + 5'd1;
	assign n_fb       = n_shift_q[0] ^ (n_tap_q ? n_shift_q[6] : n_shift_q[1]);
	assign n_shift_new = {n_fb, n_shift_q[14:1]};
	assign vol_prod   = mul_prod[17:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (func == FUNC_TICK) ? S_P_CHK : S_EVENT;
				end
			end
			S_EVENT: begin
				if (func_q == FUNC_PSTART && voice_ok && sus_q < 7'd100) begin
					state_d = S_TGT;
				end else if (func_q == FUNC_DRUM) begin
					state_d = S_DRUM_MUL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TGT:       if (div_done) state_d = S_IDLE;
			S_DRUM_MUL:  if (mul_done) state_d = S_DRUM_DIV1;
			S_DRUM_DIV1: if (div_done) state_d = S_DRUM_DIV2;
			S_DRUM_DIV2: if (div_done) state_d = S_IDLE;
			S_P_CHK: begin
				state_d = (p_active_q[idx_q] && p_level_q[idx_q] != 17'd0) ? S_P_GAIN : S_P_ENV;
			end
			S_P_GAIN: if (mul_done) state_d = S_P_ENV;
			S_P_ENV: begin
				state_d = (p_active_q[idx_q] && p_left_q[idx_q] != 20'd0) ? S_P_ENVMUL : S_P_NEXT;
			end
			S_P_ENVMUL: if (mul_done) state_d = S_P_ENVDIV;
			S_P_ENVDIV: if (div_done) state_d = S_P_NEXT;
			S_P_NEXT: begin
				state_d = (idx_q == PIW'(NUM_PULSE - 1)) ? S_TRI_CHK : S_P_CHK;
			end
			S_TRI_CHK:   state_d = t_active_q ? S_TRI_MUL : S_NOISE_CHK;
			S_TRI_MUL:   if (mul_done) state_d = S_TRI_DIV;
			S_TRI_DIV:   if (div_done) state_d = S_NOISE_CHK;
			S_NOISE_CHK: state_d = (n_level_q != 17'd0) ? S_NOISE_MUL : S_VOL_CHK;
			S_NOISE_MUL: if (mul_done) state_d = S_VOL_CHK;
			S_VOL_CHK: begin
				state_d = (music_enable_q && vol != 4'd0 && mix_q != 12'sd0) ? S_VOL_MUL : S_OUT;
			end
			S_VOL_MUL: if (mul_done) state_d = S_OUT;
			S_OUT: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and unit requests.
	always_comb begin
		in_ready         = (state_q == S_IDLE);
		mul_req          = '0;
		div_req          = '0;
		mul_req.nbits    = 5'd8;
		div_req.divisor  = 20'd1;
		unique case (state_q)
			S_DRUM_MUL: begin
				mul_req.start = !launched_q;
				mul_req.a     = OPW'(sample_rate_q);
				mul_req.b     = OPW'(drum.ms);
			end
			S_P_GAIN: begin
				mul_req.start = !launched_q;
				mul_req.a     = OPW'(p_level_q[idx_q]);
				mul_req.b     = OPW'(p_gain_q[idx_q]);
			end
			S_P_ENVMUL: begin
				mul_req.start = !launched_q;
				mul_req.a     = OPW'(p_drop);
				mul_req.b     = p_gone;
				mul_req.nbits = 5'd20;
			end
			S_TRI_MUL: begin
				mul_req.start = !launched_q;
				mul_req.a     = OPW'(t_gain_q);
				mul_req.b     = OPW'(t_mag);
				mul_req.nbits = 5'd4;
			end
			S_NOISE_MUL: begin
				mul_req.start = !launched_q;
				mul_req.a     = OPW'(n_level_q);
				mul_req.b     = OPW'(n_gain_q);
			end
			S_VOL_MUL: begin
				mul_req.start = !launched_q;
				mul_req.a     = OPW'(mix_mag);
				mul_req.b     = OPW'(vol_k);
				mul_req.nbits = 5'd7;
			end
			S_TGT: begin
				div_req.start    = !launched_q;
				div_req.dividend = PRW'({sus_q, 16'd0});
				div_req.divisor  = 20'd100;
			end
			S_DRUM_DIV1: begin
				div_req.start    = !launched_q;
				div_req.dividend = mul_prod;
				div_req.divisor  = 20'd1000;
			end
			S_DRUM_DIV2: begin
				div_req.start    = !launched_q;
				div_req.dividend = PRW'(LEVEL_FULL);
				div_req.divisor  = drum_n;
			end
			S_P_ENVDIV: begin
				div_req.start    = !launched_q;
				div_req.dividend = mul_prod;
				div_req.divisor  = p_total_q[idx_q];
			end
			S_TRI_DIV: begin
				div_req.start    = !launched_q;
				div_req.dividend = mul_prod;
				div_req.divisor  = 20'd15;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and unit launch flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start || div_req.start) begin
				launched_q <= 1'b1;
			end else if (mul_done || div_done) begin
				launched_q <= 1'b0;
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q   <= 17'd22050;
			master_volume_q <= 4'd10;
			music_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SAMPLE_RATE: sample_rate_q   <= cfg_wdata;
				REG_MASTER_VOL:  master_volume_q <= cfg_wdata[3:0];
				REG_MUSIC_EN:    music_enable_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Capture the fields of an accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			voice_q <= voice;
			inc_q   <= phase_inc;
			duty_q  <= duty_code;
			gain_q  <= gain;
			sus_q   <= sustain_pct;
			dec_q   <= decay_samples;
			kind_q  <= drum_kind;
		end
	end

	// Voice state, mix accumulation and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PULSE; i++) begin
				p_phase_q[i]  <= '0;
				p_step_q[i]   <= '0;
				p_active_q[i] <= 1'b0;
				p_duty_q[i]   <= 2'd2;
				p_gain_q[i]   <= '0;
				p_level_q[i]  <= '0;
				p_target_q[i] <= '0;
				p_total_q[i]  <= '0;
				p_left_q[i]   <= '0;
			end
			t_phase_q  <= '0;
			t_step_q   <= '0;
			t_active_q <= 1'b0;
			t_gain_q   <= '0;
			n_shift_q  <= 15'd1;
			n_tap_q    <= 1'b0;
			n_div_q    <= '0;
			n_cnt_q    <= '0;
			n_level_q  <= '0;
			n_fall_q   <= '0;
			n_gain_q   <= '0;
			idx_q      <= '0;
			mix_q      <= '0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= (func == FUNC_TICK) ? '0 : PIW'(voice);
						mix_q <= '0;
					end
				end
				S_EVENT: begin
					unique case (func_q)
						FUNC_PSTART: begin
							if (voice_ok) begin
								p_duty_q[idx_q]   <= duty_q;
								p_gain_q[idx_q]   <= gain_q;
								p_step_q[idx_q]   <= inc_q;
								p_phase_q[idx_q]  <= '0;
								p_active_q[idx_q] <= 1'b1;
								p_total_q[idx_q]  <= dec_q;
								p_left_q[idx_q]   <= dec_q;
								p_level_q[idx_q]  <= LEVEL_FULL;
								if (sus_q >= 7'd100) begin
									p_target_q[idx_q] <= LEVEL_FULL;
								end
							end
						end
						FUNC_PSTOP: begin
							if (voice_ok) begin
								p_active_q[idx_q] <= 1'b0;
								p_level_q[idx_q]  <= '0;
								p_step_q[idx_q]   <= '0;
								p_left_q[idx_q]   <= '0;
							end
						end
						FUNC_TSTART: begin
							t_gain_q   <= gain_q;
							t_step_q   <= inc_q;
							t_active_q <= 1'b1;
							t_phase_q  <= '0;
						end
						FUNC_TSTOP: begin
							t_gain_q   <= gain_q;
							t_active_q <= 1'b0;
							t_step_q   <= '0;
						end
						FUNC_DRUM: begin
							n_gain_q  <= gain_q;
							n_tap_q   <= drum.tap_sel;
							n_div_q   <= drum.clk_div;
							n_cnt_q   <= '0;
							n_level_q <= LEVEL_FULL;
						end
						default: begin
						end
					endcase
				end
				S_TGT: begin
					// Sustain target below full level; no decay starts at it.
					if (div_done) begin
						p_target_q[idx_q] <= div_quot[16:0];
						if (dec_q == 20'd0) begin
							p_level_q[idx_q] <= div_quot[16:0];
						end
					end
				end
				S_DRUM_DIV2: begin
					if (div_done) begin
						n_fall_q <= n_fall_new;
					end
				end
				S_P_GAIN: begin
					if (mul_done) begin
						mix_q <= p_pos ? mix_q + 12'(mul_prod[23:16])
						               : mix_q - 12'(mul_prod[23:16]);
						p_phase_q[idx_q] <= p_phase_q[idx_q] + p_step_q[idx_q];
					end
				end
				S_P_ENV: begin
					// Envelope without a decay in progress.
					if (!p_active_q[idx_q]) begin
						p_level_q[idx_q] <= '0;
					end else if (p_left_q[idx_q] == 20'd0) begin
						p_level_q[idx_q] <= p_target_q[idx_q];
					end
				end
				S_P_ENVDIV: begin
					// Linear decay step; the last one lands on the target.
					if (div_done) begin
						p_left_q[idx_q] <= p_left_q[idx_q] - 20'd1;
						p_level_q[idx_q] <= (p_left_q[idx_q] == 20'd1) ? p_target_q[idx_q]
						                    : LEVEL_FULL - div_quot[16:0];
					end
				end
				S_P_NEXT: begin
					if (idx_q != PIW'(NUM_PULSE - 1)) begin
						idx_q <= idx_q + PIW'(1);
					end
				end
				S_TRI_DIV: begin
					if (div_done) begin
						mix_q <= t_neg ? mix_q - 12'(div_quot[8:0])
						               : mix_q + 12'(div_quot[8:0]);
						t_phase_q <= t_phase_q + t_step_q;
					end
				end
				S_NOISE_MUL: begin
					if (mul_done) begin
						mix_q <= n_shift_q[0] ? mix_q + 12'(mul_prod[23:16])
						                      : mix_q - 12'(mul_prod[23:16]);
						if (n_cnt_inc >= n_div_q) begin
							n_cnt_q   <= '0;
							n_shift_q <= (n_shift_new == 15'd0) ? 15'd1 : n_shift_new;
						end else begin
							n_cnt_q <= n_cnt_inc;
						end
						n_level_q <= (n_level_q > n_fall_q) ? n_level_q - n_fall_q : '0;
					end
				end
				S_VOL_CHK: begin
					res_q <= '0;
				end
				S_VOL_MUL: begin
					// Scale by 11 times the volume and saturate to 16 bits.
					if (mul_done) begin
						if (!mix_neg) begin
							res_q <= (vol_prod > 18'd32767) ? 16'sh7FFF : 16'(vol_prod);
						end else begin
							res_q <= (vol_prod > 18'd32768) ? 16'sh8000 : 16'(-vol_prod);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: a finished sample waits here for the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			sample_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

@@ sv/stnvm_checker.sv @@
module stnvm_checker
	import stnvm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  func,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] sample
);

	// A waiting sample holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample))
		else $error("sample changed or dropped while stalled");

	// The block works on one transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	// A note event never produces a sample.
	a_event_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func != FUNC_TICK && !out_valid |=> !out_valid)
		else $error("sample produced by a note event");

	// A new sample appears only at the end of tick processing.
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("sample appeared while idle");

endmodule

bind square_triangle_noise_voice_mixer stnvm_checker u_stnvm_checker (.*);
